### rtl/core/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCPMQ_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication.
`define TCPMQ_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

### rtl/core/tcpmq_pkg.sv
// Shared types and constants of the two-class priority message queue.
// No dependencies.
package tcpmq_pkg;

    localparam int TAG_W    = 64;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        CMD_SEND = 1'b0,
        CMD_READ = 1'b1
    } t_command;

    typedef struct packed {
        logic    latch_in;
        logic    set_status;
        t_status status_code;
        logic    scan_clear;
        logic    scan_next;
        logic    store;
        logic    tail_link;
        logic    head_rd;
        logic    head_insert;
        logic    walk_init;
        logic    walk_link_rd;
        logic    walk_pri_rd;
        logic    walk_adv;
        logic    cur_link_rd;
        logic    link_new_wr;
        logic    link_cur_wr;
        logic    pop_rd;
        logic    pop_cap;
        logic    load_result;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic cmd_read;
        logic req_pri;
        logic slot_free;
        logic scan_last;
        logic cur_is_tail;
        logic step_done;
        logic link_null;
        logic rd_pri;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/core/tcpmq_in_if.sv
// Request channel of the message queue: valid/ready plus one request item.
// Depends on tcpmq_pkg.
interface tcpmq_in_if;
    import tcpmq_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic              priority_req;
    logic [TAG_W-1:0]  producer_tag;
    logic [WORD_W-1:0] data_word;

    modport source (output valid, command, priority_req, producer_tag, data_word,
                    input ready);
    modport sink   (input valid, command, priority_req, producer_tag, data_word,
                    output ready);
endinterface

### rtl/core/tcpmq_out_if.sv
// Result channel of the message queue: valid/ready plus one result item.
// Depends on tcpmq_pkg.
interface tcpmq_out_if;
    import tcpmq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  queued_count;
    logic                out_priority;
    logic [TAG_W-1:0]    out_producer;
    logic [WORD_W-1:0]   out_data;

    modport source (output valid, status, queued_count, out_priority, out_producer,
                    out_data, input ready);
    modport sink   (input valid, status, queued_count, out_priority, out_producer,
                    out_data, output ready);
endinterface

### rtl/core/two_class_priority_message_queue.sv
// Two-class priority message queue: linked list of messages in a slot table.
// Result paths: a rejected item, a read, a send into an empty queue, a normal send, a
// priority send placed at the head, or one that walks past the queued priority messages;
// a send with room first scans for the lowest free slot. One item at a time: the next item
// is accepted in the cycle after the result loads, and that load waits while o_res stalls.
// Reset (synchronous, active low) clears valid bits, head, tail, count, result valid; no sweep needed.
module two_class_priority_message_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRODUCER_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcpmq_in_if.sink    i_msg,
    tcpmq_out_if.source o_res
);
    import tcpmq_pkg::*;

    `include "assert_macros.svh"

    t_dp_cmd  ctrl_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    assign i_msg.ready = in_ready;

    tcpmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_msg.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    tcpmq_dp #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
        .PRODUCER_WIDTH (PRODUCER_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctrl_cmd),
        .o_stat         (dp_stat),
        .i_command      (i_msg.command),
        .i_priority_req (i_msg.priority_req),
        .i_producer_tag (i_msg.producer_tag),
        .i_data_word    (i_msg.data_word),
        .o_res          (o_res)
    );

    `TCPMQ_ASSERT_IMP(a_empty_zero_count, o_res.valid && o_res.status == ST_EMPTY, o_res.queued_count == '0, "empty status with nonzero count")
    `TCPMQ_ASSERT_NEXT(a_accept_busy, i_msg.valid && i_msg.ready, !i_msg.ready, "item accepted while busy")
    `TCPMQ_ASSERT_IMP(a_load_free, ctrl_cmd.load_result, dp_stat.out_free, "result loaded over pending result")
    `TCPMQ_ASSERT_IMP(a_store_room, ctrl_cmd.store, !dp_stat.count_full, "store into full queue")
endmodule

### rtl/core/tcpmq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tcpmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/tcpmq_ctrl.sv
// Sequencer of the message queue: steps the datapath through scan, insert and pop.
// Depends on tcpmq_pkg.
module tcpmq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcpmq_pkg::t_dp_stat i_stat,
    output tcpmq_pkg::t_dp_cmd  o_cmd
);
    import tcpmq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_STORE,
        S_TAIL_LINK,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_WALK_CHK,
        S_WALK_LINK,
        S_WALK_PRI,
        S_CUR_RD,
        S_NEW_WR,
        S_CUR_WR,
        S_POP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.cmd_read) begin
                    if (i_stat.count_zero) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_EMPTY;
                        n_state           = S_FINISH;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end
                end else if (i_stat.count_full) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_FULL;
                    n_state           = S_FINISH;
                end else begin
                    o_cmd.scan_clear = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.slot_free) begin
                    n_state = S_STORE;
                end else if (i_stat.scan_last) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_FULL;
                    n_state           = S_FINISH;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (i_stat.count_zero) begin
                    n_state = S_FINISH;
                end else if (i_stat.req_pri) begin
                    n_state = S_HEAD_RD;
                end else begin
                    n_state = S_TAIL_LINK;
                end
            end
            S_TAIL_LINK: begin
                o_cmd.tail_link = 1'b1;
                n_state         = S_FINISH;
            end
            S_HEAD_RD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HEAD_CHK;
            end
            S_HEAD_CHK: begin
                if (!i_stat.rd_pri) begin
                    o_cmd.head_insert = 1'b1;
                    n_state           = S_FINISH;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (i_stat.cur_is_tail || i_stat.step_done) begin
                    n_state = S_CUR_RD;
                end else begin
                    o_cmd.walk_link_rd = 1'b1;
                    n_state            = S_WALK_LINK;
                end
            end
            S_WALK_LINK: begin
                if (i_stat.link_null) begin
                    n_state = S_CUR_RD;
                end else begin
                    o_cmd.walk_pri_rd = 1'b1;
                    n_state           = S_WALK_PRI;
                end
            end
            S_WALK_PRI: begin
                if (!i_stat.rd_pri) begin
                    n_state = S_CUR_RD;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_WALK_CHK;
                end
            end
            S_CUR_RD: begin
                o_cmd.cur_link_rd = 1'b1;
                n_state           = S_NEW_WR;
            end
            S_NEW_WR: begin
                o_cmd.link_new_wr = 1'b1;
                n_state           = S_CUR_WR;
            end
            S_CUR_WR: begin
                o_cmd.link_cur_wr = 1'b1;
                n_state           = S_FINISH;
            end
            S_POP: begin
                o_cmd.pop_cap = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

### rtl/core/tcpmq_dp.sv
// Datapath of the message queue: slot valid bits, link and message memories,
// head/tail/count registers and the result register. Depends on tcpmq_pkg, tcpmq_ram, tcpmq_out_if.
module tcpmq_dp #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRODUCER_WIDTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcpmq_pkg::t_dp_cmd              i_cmd,
    output tcpmq_pkg::t_dp_stat             o_stat,
    input  logic                            i_command,
    input  logic                            i_priority_req,
    input  logic [tcpmq_pkg::TAG_W-1:0]     i_producer_tag,
    input  logic [tcpmq_pkg::WORD_W-1:0]    i_data_word,
    tcpmq_out_if.source                     o_res
);
    import tcpmq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = 1 + PRODUCER_WIDTH + PAYLOAD_WIDTH;
    localparam logic [LW-1:0] NO_LINK   = LW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] DEPTH_CNT = LW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);

    logic [QUEUE_DEPTH-1:0]    r_valid;
    logic [IW-1:0]             r_head;
    logic [IW-1:0]             r_tail;
    logic [LW-1:0]             r_count;
    logic                      r_out_valid;

    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             r_cur;
    logic [IW-1:0]             r_nx;
    logic [LW-1:0]             r_step;
    logic                      r_req_cmd;
    logic                      r_req_pri;
    logic [PRODUCER_WIDTH-1:0] r_req_prod;
    logic [PAYLOAD_WIDTH-1:0]  r_req_data;
    t_status                   r_res_status;
    logic                      r_res_pri;
    logic [PRODUCER_WIDTH-1:0] r_res_prod;
    logic [PAYLOAD_WIDTH-1:0]  r_res_data;
    logic [STATUS_W-1:0]       r_out_status;
    logic [COUNT_W-1:0]        r_out_count;
    logic                      r_out_pri;
    logic [TAG_W-1:0]          r_out_prod;
    logic [WORD_W-1:0]         r_out_data;

    logic                      link_we;
    logic [IW-1:0]             link_waddr;
    logic [LW-1:0]             link_wdata;
    logic                      link_re;
    logic [IW-1:0]             link_raddr;
    logic [LW-1:0]             link_rdata;
    logic                      msg_re;
    logic [IW-1:0]             msg_raddr;
    logic [MW-1:0]             msg_rdata;

    logic                      rd_pri;
    logic [PRODUCER_WIDTH-1:0] rd_prod;
    logic [PAYLOAD_WIDTH-1:0]  rd_data;
    logic                      link_null;
    logic                      count_zero;
    logic                      cur_is_tail;
    logic                      out_free;
    logic [63:0]               req_prod_ext;
    logic [63:0]               req_data_ext;
    logic [63:0]               res_data_ext;
    logic [15:0]               count_ext;

    assign rd_pri      = msg_rdata[MW-1];
    assign rd_prod     = msg_rdata[MW-2 -: PRODUCER_WIDTH];
    assign rd_data     = msg_rdata[PAYLOAD_WIDTH-1:0];
    assign link_null   = (link_rdata >= NO_LINK);
    assign count_zero  = (r_count == '0);
    assign cur_is_tail = (r_cur == r_tail);
    assign out_free    = !r_out_valid || o_res.ready;

    assign req_prod_ext = 64'(i_producer_tag);
    assign req_data_ext = 64'(i_data_word);
    assign res_data_ext = 64'(r_res_data);
    assign count_ext    = 16'(r_count);

    assign o_stat.count_zero  = count_zero;
    assign o_stat.count_full  = (r_count >= DEPTH_CNT);
    assign o_stat.cmd_read    = (r_req_cmd == CMD_READ);
    assign o_stat.req_pri     = r_req_pri;
    assign o_stat.slot_free   = !r_valid[r_idx];
    assign o_stat.scan_last   = (r_idx == LAST_SLOT);
    assign o_stat.cur_is_tail = cur_is_tail;
    assign o_stat.step_done   = (r_step == DEPTH_CNT);
    assign o_stat.link_null   = link_null;
    assign o_stat.rd_pri      = rd_pri;
    assign o_stat.out_free    = out_free;

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_idx;
        link_wdata = NO_LINK;
        if (i_cmd.store) begin
            link_we = 1'b1;
        end else if (i_cmd.tail_link) begin
            link_we    = 1'b1;
            link_waddr = r_tail;
            link_wdata = LW'(r_idx);
        end else if (i_cmd.head_insert) begin
            link_we    = 1'b1;
            link_wdata = LW'(r_head);
        end else if (i_cmd.link_new_wr) begin
            link_we    = 1'b1;
            link_wdata = link_rdata;
        end else if (i_cmd.link_cur_wr) begin
            link_we    = 1'b1;
            link_waddr = r_cur;
            link_wdata = LW'(r_idx);
        end
    end

    assign link_re    = i_cmd.walk_link_rd || i_cmd.cur_link_rd || i_cmd.pop_rd;
    assign link_raddr = i_cmd.pop_rd ? r_head : r_cur;
    assign msg_re     = i_cmd.head_rd || i_cmd.walk_pri_rd || i_cmd.pop_rd;
    assign msg_raddr  = i_cmd.walk_pri_rd ? link_rdata[IW-1:0] : r_head;

    tcpmq_ram #(
        .WIDTH (LW),
        .DEPTH (QUEUE_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    tcpmq_ram #(
        .WIDTH (MW),
        .DEPTH (QUEUE_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_idx),
        .i_wdata ({r_req_pri, r_req_prod, r_req_data}),
        .i_re    (msg_re),
        .i_raddr (msg_raddr),
        .o_rdata (msg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_valid[r_idx] <= 1'b1;
                r_count        <= r_count + LW'(1);
                if (count_zero) begin
                    r_head <= r_idx;
                    r_tail <= r_idx;
                end
            end
            if (i_cmd.tail_link) begin
                r_tail <= r_idx;
            end
            if (i_cmd.head_insert) begin
                r_head <= r_idx;
            end
            if (i_cmd.cur_link_rd && cur_is_tail) begin
                r_tail <= r_idx;
            end
            if (i_cmd.pop_rd) begin
                r_valid[r_head] <= 1'b0;
                r_count         <= r_count - LW'(1);
            end
            if (i_cmd.pop_cap && !link_null) begin
                r_head <= link_rdata[IW-1:0];
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_req_cmd    <= i_command;
            r_req_pri    <= i_priority_req;
            r_req_prod   <= req_prod_ext[PRODUCER_WIDTH-1:0];
            r_req_data   <= req_data_ext[PAYLOAD_WIDTH-1:0];
            r_res_status <= ST_OK;
            r_res_pri    <= 1'b0;
            r_res_prod   <= '0;
            r_res_data   <= '0;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status_code;
        end
        if (i_cmd.scan_clear) begin
            r_idx <= '0;
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.walk_init) begin
            r_cur  <= r_head;
            r_step <= '0;
        end else if (i_cmd.walk_adv) begin
            r_cur  <= r_nx;
            r_step <= r_step + LW'(1);
        end
        if (i_cmd.walk_pri_rd) begin
            r_nx <= link_rdata[IW-1:0];
        end
        if (i_cmd.pop_cap) begin
            r_res_pri  <= rd_pri;
            r_res_prod <= rd_prod;
            r_res_data <= rd_data;
        end
        if (i_cmd.load_result) begin
            r_out_status <= r_res_status;
            r_out_count  <= count_ext[COUNT_W-1:0];
            r_out_pri    <= r_res_pri;
            r_out_prod   <= TAG_W'(r_res_prod);
            r_out_data   <= res_data_ext[WORD_W-1:0];
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.queued_count = r_out_count;
    assign o_res.out_priority = r_out_pri;
    assign o_res.out_producer = r_out_prod;
    assign o_res.out_data     = r_out_data;
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench of two_class_priority_message_queue: directed and random send/read items,
// each result checked against a two-class FIFO predictor. Uses tcpmq_pkg and both channel interfaces.
module tb;
    import tcpmq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic              pri;
        logic [TAG_W-1:0]  tag;
        logic [WORD_W-1:0] word;
    } t_message;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                pri;
        logic [TAG_W-1:0]    tag;
        logic [WORD_W-1:0]   word;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    tcpmq_in_if  msg_if();
    tcpmq_out_if res_if();

    two_class_priority_message_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_res   (res_if)
    );

    t_message urgent_msgs[$];
    t_message normal_msgs[$];
    t_result  expected_results[$];
    int       fail_count    = 0;
    int       src_idle_pct  = 0;
    int       sink_idle_pct = 0;
    int       sink_hold     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // priority messages leave in arrival order ahead of all normal ones
    function automatic t_result predict_queue(input t_command cmd, input logic pri,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [WORD_W-1:0] word);
        t_result  r;
        t_message m;
        r = '0;
        if (cmd == CMD_READ) begin
            if (urgent_msgs.size() + normal_msgs.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                if (urgent_msgs.size() != 0) m = urgent_msgs.pop_front();
                else m = normal_msgs.pop_front();
                r.status = ST_OK;
                r.pri    = m.pri;
                r.tag    = m.tag;
                r.word   = m.word;
            end
        end else if (urgent_msgs.size() + normal_msgs.size() >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            m.pri  = pri;
            m.tag  = tag;
            m.word = word;
            if (pri) urgent_msgs.push_back(m);
            else normal_msgs.push_back(m);
            r.status = ST_OK;
        end
        r.count = COUNT_W'(urgent_msgs.size() + normal_msgs.size());
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : sink_side
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no expectation waiting: status 0x%0h", res_if.status);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(res_if.status));
                check_field("queued_count", 64'(want.count), 64'(res_if.queued_count));
                check_field("out_priority", 64'(want.pri), 64'(res_if.out_priority));
                check_field("out_producer", 64'(want.tag), 64'(res_if.out_producer));
                check_field("out_data", 64'(want.word), 64'(res_if.out_data));
            end
        end
        if (sink_hold > 0) begin
            res_if.ready <= 1'b0;
            sink_hold    <= sink_hold - 1;
        end else if ($urandom_range(99) < sink_idle_pct) begin
            res_if.ready <= 1'b0;
            sink_hold    <= $urandom_range(16);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic send_item(input t_command cmd, input logic pri,
                             input logic [TAG_W-1:0] tag, input logic [WORD_W-1:0] word);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(17, 1) : 0;
        if (gap != 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_if.valid        <= 1'b1;
        msg_if.command      <= cmd;
        msg_if.priority_req <= pri;
        msg_if.producer_tag <= tag;
        msg_if.data_word    <= word;
        @(posedge i_clk);
        while (!msg_if.ready) @(posedge i_clk);
        expected_results.push_back(predict_queue(cmd, pri, tag, word));
    endtask

    task automatic wait_drained();
        msg_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic [TAG_W-1:0] random_tag();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_and_last_message();
        send_item(CMD_READ, 1'b1, '1, '1);
        send_item(CMD_SEND, 1'b0, '0, '0);
        send_item(CMD_READ, 1'b0, '0, '0);
        send_item(CMD_READ, 1'b0, '0, '0);
        send_item(CMD_SEND, 1'b1, '1, '1);
        send_item(CMD_READ, 1'b0, '1, '1);
    endtask

    // alternating classes: priority in front of a normal head, then after the last priority
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH; i++) begin
            send_item(CMD_SEND, i[0], {16{4'(i)}}, {8{4'(~i)}});
        end
        send_item(CMD_SEND, 1'b1, '1, '1);
        send_item(CMD_SEND, 1'b0, '0, '0);
        repeat (4) send_item(CMD_READ, 1'b0, '0, '0);
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int urgent_pct);
        repeat (n_items) begin
            if ($urandom_range(99) < send_pct) begin
                send_item(CMD_SEND, $urandom_range(99) < urgent_pct, random_tag(),
                          random_word());
            end else begin
                send_item(CMD_READ, 1'($urandom_range(1)), random_tag(), random_word());
            end
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        msg_if.valid        = 1'b0;
        msg_if.command      = CMD_SEND;
        msg_if.priority_req = 1'b0;
        msg_if.producer_tag = '0;
        msg_if.data_word    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_last_message();
        test_full_queue();

        src_idle_pct  = 30;
        sink_idle_pct = 30;
        test_random_traffic(300, 60, 40);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(150, 50, 50);
        wait_drained();

        src_idle_pct  = 20;
        sink_idle_pct = 50;
        test_random_traffic(300, 75, 30);
        test_random_traffic(300, 30, 60);
        wait_drained();

        src_idle_pct  = 50;
        sink_idle_pct = 10;
        test_random_traffic(300, 55, 50);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(270, 55, 40);

        msg_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/tcpmq_pkg.sv
rtl/core/tcpmq_in_if.sv
rtl/core/tcpmq_out_if.sv
rtl/core/tcpmq_ram.sv
rtl/core/tcpmq_ctrl.sv
rtl/core/tcpmq_dp.sv
rtl/core/two_class_priority_message_queue.sv
bench/tb.sv
